@@ rtl/double_ended_queue_unit_defines.svh @@
// Assertion helpers shared by the deque controller and datapath.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/deq_pkg.sv @@
package deq_pkg;

	localparam int WORD_W = 32;

	// action codes
	localparam logic [1:0] ACT_PUSH_FRONT = 2'd0;
	localparam logic [1:0] ACT_PUSH_REAR  = 2'd1;
	localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
	localparam logic [1:0] ACT_POP_REAR   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	localparam logic [WORD_W-1:0] NO_WORD = '1;

	// controller to datapath
	typedef struct packed {
		logic step;     // take the accepted item: update pointers, count, store
		logic capture;  // load the output register from the store read data
	} deq_cmd_t;

endpackage

@@ rtl/deq_ram.sv @@
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

@@ rtl/deq_ctrl.sv @@
`include "double_ended_queue_unit_defines.svh"

module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output deq_pkg::deq_cmd_t cmd
);

	import deq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_CAP  = 2'd2;

	logic [1:0] state_q;
	logic       m_tvalid_q;

	assign s_tready    = (state_q == S_IDLE);
	assign cmd.step    = s_tvalid && (state_q == S_IDLE);
	assign cmd.capture = (state_q == S_CAP) && (!m_tvalid_q || m_tready);
	assign m_tvalid    = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.step) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CAP;
				end
				S_CAP: begin
					if (cmd.capture) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the result until taken; a new capture refills it in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.capture) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	`DEQ_ASSERT_NEXT(a_step_to_read, cmd.step, state_q == S_READ, "step did not start read")
	`DEQ_ASSERT_NEXT(a_read_to_cap, state_q == S_READ, state_q == S_CAP, "read not followed by capture")
	`DEQ_ASSERT_NEXT(a_cap_valid, cmd.capture, m_tvalid_q, "capture did not raise valid")
	`DEQ_ASSERT_NOW(a_cap_free, cmd.capture, !m_tvalid_q || m_tready, "capture over held result")

endmodule

@@ rtl/deq_datapath.sv @@
`include "double_ended_queue_unit_defines.svh"

module deq_datapath #(
	parameter int DEPTH = 16,
	parameter int CW    = 5,
	parameter int TW    = 104
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  deq_pkg::deq_cmd_t         cmd,
	input  logic [1:0]                action,
	input  logic [deq_pkg::WORD_W-1:0] push_value,
	output logic [TW-1:0]             m_tdata,
	output logic [1:0]                m_tuser
);

	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] cnt_q;
	logic [WORD_W-1:0] popped_q;
	logic [1:0] status_q;

	logic [WORD_W-1:0] out_popped_q, out_front_q, out_rear_q;
	logic [CW-1:0]     out_cnt_q;
	logic              out_empty_q, out_full_q;
	logic [1:0]        out_status_q;

	logic [AW-1:0] head_prev, head_next, tail_prev, tail_next;
	logic          is_empty, is_full, is_push;
	logic          we;
	logic [AW-1:0] waddr;
	logic [WORD_W-1:0] rd_head, rd_tail;

	assign head_prev = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
	assign tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;

	assign is_empty = (cnt_q == '0);
	assign is_full  = (cnt_q == FULL_CNT);
	assign is_push  = (action == ACT_PUSH_FRONT) || (action == ACT_PUSH_REAR);

	assign we    = cmd.step && is_push && !is_full;
	assign waddr = (action == ACT_PUSH_FRONT) ? head_prev : tail_next;

	deq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (push_value),
		.raddr_a(head_q),
		.raddr_b(tail_q),
		.rdata_a(rd_head),
		.rdata_b(rd_tail)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= LAST_IDX;
			cnt_q  <= '0;
		end else if (cmd.step) begin
			unique case (action)
				ACT_PUSH_FRONT: begin
					if (!is_full) begin
						head_q <= head_prev;
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				ACT_PUSH_REAR: begin
					if (!is_full) begin
						tail_q <= tail_next;
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				ACT_POP_FRONT: begin
					if (!is_empty) begin
						head_q <= head_next;
						cnt_q  <= cnt_q - 1'b1;
					end
				end
				ACT_POP_REAR: begin
					if (!is_empty) begin
						tail_q <= tail_prev;
						cnt_q  <= cnt_q - 1'b1;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// Popped word comes from the previous result's front or rear word.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			popped_q <= NO_WORD;
			status_q <= ST_OK;
			if (is_push) begin
				if (is_full) begin
					status_q <= ST_OVERFLOW;
				end
			end else if (is_empty) begin
				status_q <= ST_UNDERFLOW;
			end else if (action == ACT_POP_FRONT) begin
				popped_q <= out_front_q;
			end else begin
				popped_q <= out_rear_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			out_popped_q <= popped_q;
			out_status_q <= status_q;
			out_cnt_q    <= cnt_q;
			out_empty_q  <= is_empty;
			out_full_q   <= is_full;
			out_front_q  <= is_empty ? '0 : rd_head;
			out_rear_q   <= is_empty ? '0 : rd_tail;
		end
	end

	assign m_tdata = TW'({out_rear_q, out_front_q, out_full_q, out_empty_q,
		out_cnt_q, out_popped_q});
	assign m_tuser = out_status_q;

	`DEQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= FULL_CNT, "count beyond depth")
	`DEQ_ASSERT_NEXT(a_push_inc, we, cnt_q == $past(cnt_q) + 1'b1, "push did not advance count")
	`DEQ_ASSERT_NEXT(a_pop_dec, cmd.step && !is_push && !is_empty,
		cnt_q == $past(cnt_q) - 1'b1, "pop did not reduce count")

endmodule

@@ rtl/double_ended_queue_unit.sv @@
// Channel   Direction  tdata                     tuser
// s_*       in         push_value[31:0]          action[1:0]
// m_*       out        popped,count,flags,words  status[1:0]
//
// Each item passes through accept (pointers, count and store write),
// read of the head and tail entries through the store's two read ports,
// and capture into the output register; the read step exists because the
// store read is registered. A held result stalls only the capture cycle;
// the next item is accepted as soon as the previous one is captured. Reset
// sets the pointers to their start and clears count at once; the store has no clearing pass.
module double_ended_queue_unit #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata,  // push_value[31:0]
	input  logic [1:0]  s_tuser,  // action[1:0]
	output logic m_tvalid,
	input  logic m_tready,
	// popped_value[31:0], entry_count[CW-1:0], is_empty, is_full,
	// front_word[31:0], rear_word[31:0], zero fill to whole bytes
	output logic [((98 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
	output logic [1:0]  m_tuser   // status[1:0]
);

	import deq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int TW = ((98 + CW + 7) / 8) * 8;

	deq_cmd_t cmd;

	// Sequence each transfer: accept, read, capture.
	deq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd)
	);

	// Hold pointers, count, the word store and the output register.
	deq_datapath #(
		.DEPTH(DEPTH),
		.CW   (CW),
		.TW   (TW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.action    (s_tuser),
		.push_value(s_tdata[WORD_W-1:0]),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
